### rtl/grcs_pkg.sv
// Shared types and constants for the grid region color statistics block.
// Used by grcs_front, grcs_back and grid_region_color_stats.
`timescale 1ns / 1ps
`default_nettype none
package grcs_pkg;

	localparam int DIM_W  = 13;   // image size, 1..4096
	localparam int CRD_W  = 12;   // pixel coordinate
	localparam int GRID_W = 6;    // cell index
	localparam int GCNT_W = 7;    // cell count, 1..64
	localparam int PIX_W  = 8;
	localparam int SUM_W  = 24;
	localparam int CNT_W  = 16;

	localparam logic [DIM_W-1:0]  MAX_DIM  = 13'd4096;
	localparam logic [GCNT_W-1:0] MAX_GRID = 7'd64;

	localparam logic [DIM_W-1:0]  RST_WIDTH  = 13'd640;
	localparam logic [DIM_W-1:0]  RST_HEIGHT = 13'd480;
	localparam logic [GCNT_W-1:0] RST_COLS   = 7'd10;
	localparam logic [GCNT_W-1:0] RST_ROWS   = 7'd10;

	// (s * 683) >> 11 == s / 3 for s <= 765
	localparam logic [9:0] DIV3_MUL = 10'd683;

	typedef enum logic [1:0] {
		REG_IMAGE_WIDTH  = 2'd0,
		REG_IMAGE_HEIGHT = 2'd1,
		REG_GRID_COLS    = 2'd2,
		REG_GRID_ROWS    = 2'd3
	} cfg_reg_t;

	typedef struct packed {
		logic [SUM_W-1:0] red_sum;
		logic [SUM_W-1:0] green_sum;
		logic [SUM_W-1:0] blue_sum;
		logic [CNT_W-1:0] count;
		logic [PIX_W-1:0] min_br;
		logic [PIX_W-1:0] max_br;
	} acc_t;

	localparam acc_t ACC_RESET = '{
		red_sum: '0, green_sum: '0, blue_sum: '0, count: '0,
		min_br: 8'hFF, max_br: 8'h00
	};

	typedef struct packed {
		logic [GRID_W-1:0] cell_row;
		logic [GRID_W-1:0] cell_col;
		acc_t              acc;
		logic [CRD_W-1:0]  center_x;
		logic [CRD_W-1:0]  center_y;
		logic              last;
	} cell_stats_t;

endpackage
`default_nettype wire

### rtl/grcs_div.sv
// Iterative restoring divider, one quotient bit per cycle.
// Standalone; no package dependency.
`timescale 1ns / 1ps
`default_nettype none
module grcs_div #(
	parameter int NUM_W = 24,
	parameter int DEN_W = 16
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             start,
	input  wire logic [NUM_W-1:0] num,
	input  wire logic [DEN_W-1:0] den,
	output logic                  done,
	output logic [NUM_W-1:0]      quo,
	output logic [DEN_W-1:0]      rem
);
	localparam int STEP_W = $clog2(NUM_W + 1);

	logic              busy_q, done_q;
	logic [STEP_W-1:0] step_q;
	logic [NUM_W-1:0]  num_q;
	logic [DEN_W-1:0]  rem_q, den_q;
	logic [DEN_W:0]    trial, diff;
	logic              ge;

	assign trial = {rem_q, num_q[NUM_W-1]};
	assign ge    = trial >= {1'b0, den_q};
	assign diff  = trial - {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
			num_q  <= '0;
			rem_q  <= '0;
			den_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				step_q <= '0;
				num_q  <= num;
				den_q  <= den;
				rem_q  <= '0;
			end else if (busy_q) begin
				num_q  <= {num_q[NUM_W-2:0], ge};
				rem_q  <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
				step_q <= step_q + 1'b1;
				if (step_q == STEP_W'(NUM_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign done = done_q;
	assign quo  = num_q;
	assign rem  = rem_q;
endmodule
`default_nettype wire

### rtl/grcs_fifo.sv
// Small register queue between the accumulate front end and the divide back end.
// Standalone; width set by parameter.
`timescale 1ns / 1ps
`default_nettype none
module grcs_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	input  wire logic [WIDTH-1:0] din,
	output logic                  full,
	input  wire logic             pop,
	output logic [WIDTH-1:0]      dout,
	output logic                  empty
);
	localparam int AW = $clog2(DEPTH);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [AW-1:0]    wp_q, rp_q;
	logic [AW:0]      cnt_q;
	logic             do_push, do_pop;

	assign full    = cnt_q == (AW+1)'(DEPTH);
	assign empty   = cnt_q == '0;
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign dout    = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wp_q] <= din;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) begin
				wp_q <= (wp_q == AW'(DEPTH - 1)) ? '0 : wp_q + 1'b1;
			end
			if (do_pop) begin
				rp_q <= (rp_q == AW'(DEPTH - 1)) ? '0 : rp_q + 1'b1;
			end
			cnt_q <= cnt_q + (AW+1)'(do_push) - (AW+1)'(do_pop);
		end
	end
endmodule
`default_nettype wire

### rtl/grcs_front.sv
// Front end: config registers, raster position and cell bound stepping, sampling,
// per-column accumulator memory and the end-of-cell-row sweep. Uses grcs_pkg, grcs_div.
`timescale 1ns / 1ps
`default_nettype none
module grcs_front (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 cfg_valid,
	output logic                      cfg_ready,
	input  wire grcs_pkg::cfg_reg_t   cfg_index,
	input  wire logic [12:0]          cfg_data,
	input  wire logic                 s_tvalid,
	output logic                      s_tready,
	input  wire logic [23:0]          s_tdata,
	output logic                      q_push,
	input  wire logic                 q_full,
	output grcs_pkg::cell_stats_t     q_data
);
	import grcs_pkg::*;

	typedef enum logic [6:0] {
		F_INIT_GO   = 7'b0000001,
		F_INIT_WAIT = 7'b0000010,
		F_IDLE      = 7'b0000100,
		F_RD        = 7'b0001000,
		F_WR        = 7'b0010000,
		F_SW_RD     = 7'b0100000,
		F_SW_PUSH   = 7'b1000000
	} fstate_t;

	fstate_t state_q;

	logic [DIM_W-1:0]  cfg_w_q, cfg_h_q;
	logic [GCNT_W-1:0] cfg_c_q, cfg_r_q;
	logic [DIM_W-1:0]  w_eff, h_eff;
	logic [GCNT_W-1:0] c_lim, r_lim, c_eff, r_eff;

	logic [DIM_W-1:0]  w_q, h_q;
	logic [GCNT_W-1:0] nc_q, nr_q;
	logic [DIM_W-1:0]  qx_q, qy_q;
	logic [GCNT_W-1:0] rxs_q, rys_q;

	logic [CRD_W-1:0]  x_q, y_q;
	logic [GRID_W-1:0] col_q, row_q;
	logic [DIM_W-1:0]  x0_q, x1_q, y0_q, y1_q;
	logic [GCNT_W-1:0] rx_q, ry_q;
	logic [DIM_W-1:0]  ox_q, pa_q, pb_q;
	logic [63:0]       valid_q;

	logic [PIX_W-1:0]  red_s1, green_s1, blue_s1;
	logic [GRID_W-1:0] col_s1;
	logic              smp_s1, emit_s1;
	logic [GRID_W-1:0] row_e_q;
	logic [CRD_W-1:0]  cy_q;

	acc_t              mem_q [64];
	acc_t              rd_q, base, upd;
	logic [GRID_W-1:0] ra;
	logic              mem_we;

	logic              dvx_done, dvy_done;
	logic [DIM_W-1:0]  dvx_quo, dvy_quo;
	logic [GCNT_W-1:0] dvx_rem, dvy_rem;

	logic [DIM_W-1:0]  dx, dy, min_a, min_b, qx_p1, sa, sb, sx, y_ph;
	logic              narrow, last_x, emit, sample, last_col;
	logic [GCNT_W:0]   csum, rsum;
	logic              cwrap, rwrap;
	logic [DIM_W-1:0]  x1_nx, y1_nx;
	logic [GCNT_W-1:0] rx_nx, ry_nx;
	logic [DIM_W-1:0]  ox_inc, pa_inc, pb_inc;
	logic [CRD_W:0]    y_inc;
	logic [9:0]        br_sum;
	logic [19:0]       br_prod;
	logic [PIX_W-1:0]  br;
	logic [DIM_W:0]    cx_sum, cy_sum;

	// effective sizes
	always_comb begin
		w_eff = (cfg_w_q == '0) ? DIM_W'(1) : (cfg_w_q > MAX_DIM) ? MAX_DIM : cfg_w_q;
		h_eff = (cfg_h_q == '0) ? DIM_W'(1) : (cfg_h_q > MAX_DIM) ? MAX_DIM : cfg_h_q;
		c_lim = (cfg_c_q == '0) ? GCNT_W'(1) : (cfg_c_q > MAX_GRID) ? MAX_GRID : cfg_c_q;
		r_lim = (cfg_r_q == '0) ? GCNT_W'(1) : (cfg_r_q > MAX_GRID) ? MAX_GRID : cfg_r_q;
		c_eff = ({6'd0, c_lim} > w_eff) ? w_eff[GCNT_W-1:0] : c_lim;
		r_eff = ({6'd0, r_lim} > h_eff) ? h_eff[GCNT_W-1:0] : r_lim;
	end

	grcs_div #(.NUM_W(DIM_W), .DEN_W(GCNT_W)) u_div_x (
		.clk(clk), .arst_n(arst_n), .start(state_q == F_INIT_GO),
		.num(w_eff), .den(c_eff), .done(dvx_done), .quo(dvx_quo), .rem(dvx_rem)
	);

	grcs_div #(.NUM_W(DIM_W), .DEN_W(GCNT_W)) u_div_y (
		.clk(clk), .arst_n(arst_n), .start(state_q == F_INIT_GO),
		.num(h_eff), .den(r_eff), .done(dvy_done), .quo(dvy_quo), .rem(dvy_rem)
	);

	always_comb begin
		dx     = x1_q - x0_q;
		dy     = y1_q - y0_q;
		qx_p1  = qx_q + 1'b1;
		min_a  = (qx_q < dy) ? qx_q : dy;
		min_b  = (qx_p1 < dy) ? qx_p1 : dy;
		sa     = (min_a[DIM_W-1:3] == '0) ? DIM_W'(1) : (min_a >> 3);
		sb     = (min_b[DIM_W-1:3] == '0) ? DIM_W'(1) : (min_b >> 3);
		narrow = dx == qx_q;
		sx     = narrow ? sa : sb;
		y_ph   = narrow ? pa_q : pb_q;
		sample = (ox_q == '0) && (y_ph == '0);
		last_x = {1'b0, x_q} == w_q - 1'b1;
		emit   = last_x && ({1'b0, y_q} == y1_q - 1'b1);
		ox_inc = ox_q + 1'b1;
		pa_inc = pa_q + 1'b1;
		pb_inc = pb_q + 1'b1;
		y_inc  = {1'b0, y_q} + 1'b1;

		csum   = {1'b0, rx_q} + {1'b0, rxs_q};
		cwrap  = csum >= {1'b0, nc_q};
		x1_nx  = x1_q + qx_q + DIM_W'(cwrap);
		rx_nx  = cwrap ? GCNT_W'(csum - {1'b0, nc_q}) : csum[GCNT_W-1:0];
		rsum   = {1'b0, ry_q} + {1'b0, rys_q};
		rwrap  = rsum >= {1'b0, nr_q};
		y1_nx  = y1_q + qy_q + DIM_W'(rwrap);
		ry_nx  = rwrap ? GCNT_W'(rsum - {1'b0, nr_q}) : rsum[GCNT_W-1:0];

		last_col = {1'b0, col_q} == nc_q - 1'b1;
		cx_sum   = {1'b0, x0_q} + {1'b0, x1_q};
		cy_sum   = {1'b0, y0_q} + {1'b0, y1_q};
	end

	// sample update
	always_comb begin
		base    = valid_q[col_s1] ? rd_q : ACC_RESET;
		br_sum  = {2'b0, red_s1} + {2'b0, green_s1} + {2'b0, blue_s1};
		br_prod = br_sum * DIV3_MUL;
		br      = br_prod[18:11];
		upd     = base;
		if (smp_s1) begin
			upd.red_sum   = base.red_sum + SUM_W'(red_s1);
			upd.green_sum = base.green_sum + SUM_W'(green_s1);
			upd.blue_sum  = base.blue_sum + SUM_W'(blue_s1);
			upd.count     = base.count + 1'b1;
			upd.min_br    = (br < base.min_br) ? br : base.min_br;
			upd.max_br    = (br > base.max_br) ? br : base.max_br;
		end
	end

	assign ra     = (state_q == F_RD) ? col_s1 : col_q;
	assign mem_we = state_q == F_WR;

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem_q[col_s1] <= upd;
		end
		rd_q <= mem_q[ra];
	end

	always_comb begin
		q_data.cell_row = row_e_q;
		q_data.cell_col = col_q;
		q_data.acc      = valid_q[col_q] ? rd_q : ACC_RESET;
		q_data.center_x = cx_sum[DIM_W-1:1];
		q_data.center_y = cy_q;
		q_data.last     = last_col;
	end

	// config only between pixels; a pending write takes precedence over a pixel
	assign q_push    = (state_q == F_SW_PUSH) && !q_full;
	assign s_tready  = (state_q == F_IDLE) && !cfg_valid;
	assign cfg_ready = (state_q == F_IDLE) || (state_q == F_INIT_GO) ||
	                   (state_q == F_INIT_WAIT);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_INIT_GO;
			cfg_w_q <= RST_WIDTH;
			cfg_h_q <= RST_HEIGHT;
			cfg_c_q <= RST_COLS;
			cfg_r_q <= RST_ROWS;
			w_q <= '0; h_q <= '0; nc_q <= '0; nr_q <= '0;
			qx_q <= '0; qy_q <= '0; rxs_q <= '0; rys_q <= '0;
			x_q <= '0; y_q <= '0; col_q <= '0; row_q <= '0;
			x0_q <= '0; x1_q <= '0; y0_q <= '0; y1_q <= '0;
			rx_q <= '0; ry_q <= '0; ox_q <= '0; pa_q <= '0; pb_q <= '0;
			valid_q <= '0;
			red_s1 <= '0; green_s1 <= '0; blue_s1 <= '0;
			col_s1 <= '0; smp_s1 <= 1'b0; emit_s1 <= 1'b0;
			row_e_q <= '0; cy_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_IMAGE_WIDTH:  cfg_w_q <= cfg_data;
				REG_IMAGE_HEIGHT: cfg_h_q <= cfg_data;
				REG_GRID_COLS:    cfg_c_q <= cfg_data[GCNT_W-1:0];
				REG_GRID_ROWS:    cfg_r_q <= cfg_data[GCNT_W-1:0];
				default:          cfg_w_q <= cfg_w_q;
			endcase
			valid_q <= '0;
			state_q <= F_INIT_GO;
		end else begin
			unique case (state_q)
				F_INIT_GO: begin
					w_q     <= w_eff;
					h_q     <= h_eff;
					nc_q    <= c_eff;
					nr_q    <= r_eff;
					valid_q <= '0;
					state_q <= F_INIT_WAIT;
				end
				F_INIT_WAIT: begin
					if (dvx_done && dvy_done) begin
						qx_q  <= dvx_quo;
						rxs_q <= dvx_rem;
						qy_q  <= dvy_quo;
						rys_q <= dvy_rem;
						x_q <= '0; y_q <= '0; col_q <= '0; row_q <= '0;
						x0_q <= '0; x1_q <= dvx_quo; rx_q <= dvx_rem;
						y0_q <= '0; y1_q <= dvy_quo; ry_q <= dvy_rem;
						ox_q <= '0; pa_q <= '0; pb_q <= '0;
						state_q <= F_IDLE;
					end
				end
				F_IDLE: begin
					if (s_tvalid) begin
						red_s1   <= s_tdata[7:0];
						green_s1 <= s_tdata[15:8];
						blue_s1  <= s_tdata[23:16];
						col_s1   <= col_q;
						smp_s1   <= sample;
						emit_s1  <= emit;
						row_e_q  <= row_q;
						cy_q     <= cy_sum[DIM_W-1:1];
						if (last_x) begin
							x_q   <= '0;
							col_q <= '0;
							x0_q  <= '0;
							x1_q  <= qx_q;
							rx_q  <= rxs_q;
							ox_q  <= '0;
							if (y_inc == h_q) begin
								y_q   <= '0;
								row_q <= '0;
								y0_q  <= '0;
								y1_q  <= qy_q;
								ry_q  <= rys_q;
								pa_q  <= '0;
								pb_q  <= '0;
							end else if (y_inc == y1_q) begin
								y_q   <= y_inc[CRD_W-1:0];
								row_q <= row_q + 1'b1;
								y0_q  <= y1_q;
								y1_q  <= y1_nx;
								ry_q  <= ry_nx;
								pa_q  <= '0;
								pb_q  <= '0;
							end else begin
								y_q  <= y_inc[CRD_W-1:0];
								pa_q <= (pa_inc == sa) ? '0 : pa_inc;
								pb_q <= (pb_inc == sb) ? '0 : pb_inc;
							end
						end else begin
							x_q <= x_q + 1'b1;
							if ({1'b0, x_q} + 1'b1 == x1_q) begin
								col_q <= col_q + 1'b1;
								x0_q  <= x1_q;
								x1_q  <= x1_nx;
								rx_q  <= rx_nx;
								ox_q  <= '0;
							end else begin
								ox_q <= (ox_inc == sx) ? '0 : ox_inc;
							end
						end
						state_q <= F_RD;
					end
				end
				F_RD: begin
					state_q <= F_WR;
				end
				F_WR: begin
					valid_q[col_s1] <= 1'b1;
					state_q <= emit_s1 ? F_SW_RD : F_IDLE;
				end
				F_SW_RD: begin
					state_q <= F_SW_PUSH;
				end
				F_SW_PUSH: begin
					if (!q_full) begin
						valid_q[col_q] <= 1'b0;
						if (last_col) begin
							col_q   <= '0;
							x0_q    <= '0;
							x1_q    <= qx_q;
							rx_q    <= rxs_q;
							ox_q    <= '0;
							state_q <= F_IDLE;
						end else begin
							col_q   <= col_q + 1'b1;
							x0_q    <= x1_q;
							x1_q    <= x1_nx;
							rx_q    <= rx_nx;
							state_q <= F_SW_RD;
						end
					end
				end
				default: state_q <= F_INIT_GO;
			endcase
		end
	end
endmodule
`default_nettype wire

### rtl/grcs_back.sv
// Back end: takes raw cell statistics from the queue, divides the sums by the
// sample count and drives the output register. Uses grcs_pkg, grcs_div.
`timescale 1ns / 1ps
`default_nettype none
module grcs_back (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  q_empty,
	input  wire grcs_pkg::cell_stats_t q_data,
	output logic                       q_pop,
	output logic                       m_tvalid,
	input  wire logic                  m_tready,
	output logic [71:0]                m_tdata,
	output logic                       m_tlast
);
	import grcs_pkg::*;

	typedef enum logic [2:0] {
		B_IDLE = 3'b001,
		B_DIV  = 3'b010,
		B_HOLD = 3'b100
	} bstate_t;

	bstate_t          state_q;
	cell_stats_t      ent_q;
	logic [PIX_W-1:0] avg_r_q, avg_g_q, avg_b_q;
	logic             m_valid_q;
	logic [71:0]      m_data_q;
	logic             m_last_q;

	logic             dr_done, dg_done, db_done;
	logic [SUM_W-1:0] dr_quo, dg_quo, db_quo;
	logic [CNT_W-1:0] dr_rem, dg_rem, db_rem;
	logic             zero_cnt, load_out;
	logic [PIX_W-1:0] contrast;

	assign q_pop    = (state_q == B_IDLE) && !q_empty;
	assign zero_cnt = ent_q.acc.count == '0;
	assign load_out = (state_q == B_HOLD) && (!m_valid_q || m_tready);
	assign contrast = (ent_q.acc.max_br >= ent_q.acc.min_br)
	                ? ent_q.acc.max_br - ent_q.acc.min_br : '0;

	grcs_div #(.NUM_W(SUM_W), .DEN_W(CNT_W)) u_div_r (
		.clk(clk), .arst_n(arst_n), .start(q_pop), .num(q_data.acc.red_sum),
		.den(q_data.acc.count), .done(dr_done), .quo(dr_quo), .rem(dr_rem)
	);
	grcs_div #(.NUM_W(SUM_W), .DEN_W(CNT_W)) u_div_g (
		.clk(clk), .arst_n(arst_n), .start(q_pop), .num(q_data.acc.green_sum),
		.den(q_data.acc.count), .done(dg_done), .quo(dg_quo), .rem(dg_rem)
	);
	grcs_div #(.NUM_W(SUM_W), .DEN_W(CNT_W)) u_div_b (
		.clk(clk), .arst_n(arst_n), .start(q_pop), .num(q_data.acc.blue_sum),
		.den(q_data.acc.count), .done(db_done), .quo(db_quo), .rem(db_rem)
	);

	always_ff @(posedge clk) begin
		if (q_pop) begin
			ent_q <= q_data;
		end
		if (state_q == B_DIV && dr_done && dg_done && db_done) begin
			avg_r_q <= zero_cnt ? '0 : dr_quo[PIX_W-1:0];
			avg_g_q <= zero_cnt ? '0 : dg_quo[PIX_W-1:0];
			avg_b_q <= zero_cnt ? '0 : db_quo[PIX_W-1:0];
		end
		if (load_out) begin
			m_data_q <= {4'd0, ent_q.center_y, ent_q.center_x, contrast,
			             avg_b_q, avg_g_q, avg_r_q, ent_q.cell_col, ent_q.cell_row};
			m_last_q <= ent_q.last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= B_IDLE;
			m_valid_q <= 1'b0;
		end else begin
			if (load_out) begin
				m_valid_q <= 1'b1;
			end else if (m_tready) begin
				m_valid_q <= 1'b0;
			end
			unique case (state_q)
				B_IDLE: if (q_pop) state_q <= B_DIV;
				B_DIV: begin
					if (dr_done && dg_done && db_done) begin
						state_q <= B_HOLD;
					end
				end
				B_HOLD: if (load_out) state_q <= B_IDLE;
				default: state_q <= B_IDLE;
			endcase
		end
	end

	// remainders are not needed for the averages
	logic unused_rem;
	assign unused_rem = ^{dr_rem, dg_rem, db_rem};

	assign m_tvalid = m_valid_q;
	assign m_tdata  = m_data_q;
	assign m_tlast  = m_last_q & ~(unused_rem & 1'b0);
endmodule
`default_nettype wire

### rtl/grid_region_color_stats.sv
// Grid region color statistics: per-cell mean color and brightness contrast
// over a raster RGB stream. Uses grcs_pkg, grcs_front, grcs_fifo, grcs_back.
//
// Channels: pixels enter on s_* (one transfer per pixel, raster order); one
// result per grid column leaves on m_* when the last pixel of a cell row has
// been taken, m_tlast marking the final column. Config writes on cfg_* are
// taken between pixels (not during a pixel or a row sweep) and restart the
// frame; a pending write holds s_tready low.
// Front end: each pixel goes through accept, accumulator memory read and write back.
// At the end of a cell row it sweeps the accumulator memory column by column
// into a 4-entry queue and takes no pixel until the sweep is done.
// Back end: one result at a time, paced by the 24-step divider that forms
// the averages (three dividers run side by side).
// After reset or any config write the front computes the cell sizes with a
// 13-step divider and holds s_tready low until they are done.
// A stalled receiver holds the result in the output register; the queue then
// fills and the front stops taking pixels at the next cell row end.
`timescale 1ns / 1ps
`default_nettype none
module grid_region_color_stats (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               cfg_valid,
	output logic                    cfg_ready,
	input  wire grcs_pkg::cfg_reg_t cfg_index,
	input  wire logic [12:0]        cfg_data,
	input  wire logic               s_tvalid,
	output logic                    s_tready,
	input  wire logic [23:0]        s_tdata,   // red[7:0], green[15:8], blue[23:16]
	output logic                    m_tvalid,
	input  wire logic               m_tready,
	// cell_row[5:0], cell_col[11:6], avg_red[19:12], avg_green[27:20],
	// avg_blue[35:28], contrast[43:36], center_x[55:44], center_y[67:56]
	output logic [71:0]             m_tdata,
	output logic                    m_tlast    // last_of_row
);
	import grcs_pkg::*;

	cell_stats_t q_in, q_out;
	logic        q_push, q_full, q_pop, q_empty;

	grcs_front u_front (
		.clk(clk), .arst_n(arst_n),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.q_push(q_push), .q_full(q_full), .q_data(q_in)
	);

	grcs_fifo #(.WIDTH($bits(cell_stats_t)), .DEPTH(4)) u_queue (
		.clk(clk), .arst_n(arst_n),
		.push(q_push), .din(q_in), .full(q_full),
		.pop(q_pop), .dout(q_out), .empty(q_empty)
	);

	grcs_back u_back (
		.clk(clk), .arst_n(arst_n),
		.q_empty(q_empty), .q_data(q_out), .q_pop(q_pop),
		.m_tvalid(m_tvalid), .m_tready(m_tready),
		.m_tdata(m_tdata), .m_tlast(m_tlast)
	);
endmodule
`default_nettype wire
